/* rtl/crcwfd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package crcwfd_pkg;

    localparam logic [7:0] CRC_INIT        = 8'hFF;
    localparam logic [7:0] CRC_POLY        = 8'h31;
    localparam logic [3:0] MAX_VALUES      = 4'd10;
    localparam int         BYTES_PER_VALUE = 6;
    localparam logic [3:0] VALUES_RESET    = 4'd4;

    // byte phase inside one value: data, data, crc, data, data, crc
    localparam logic [2:0] PH_FIRST  = 3'd0;
    localparam logic [2:0] PH_CRC_HI = 3'd2;
    localparam logic [2:0] PH_CRC_LO = 3'd5;

    typedef logic [1:0] t_status;
    localparam t_status STATUS_OK        = 2'd0;
    localparam t_status STATUS_CRC_ERR   = 2'd1;
    localparam t_status STATUS_NONFINITE = 2'd2;

    // crc-8, msb first, no final xor
    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/crc_checked_word_frame_decoder_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// output: a result is registered and shows in the output register in the cycle after its last byte transfer
// throughput: one byte per cycle, set by the byte-wide crc update and value assembly
// feeding the output register; input stalls only while a held result is stalled
// reset: synchronous, active low; clears frame state, sets values_used to 4

module crc_checked_word_frame_decoder_unit #(
    parameter int FRAME_BYTES = 60
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_frame_start,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_value_bits,
    output logic [3:0]       o_value_index,
    output logic             o_value_crc_ok,
    output logic             o_value_finite,
    output logic [1:0]       o_frame_status,
    output logic             o_last
);

    localparam int         POS_W = $clog2(FRAME_BYTES + 1);
    localparam logic [3:0] CAP   = 4'(FRAME_BYTES / crcwfd_pkg::BYTES_PER_VALUE);

    logic [POS_W-1:0] r_pos, n_pos, c_pos;
    logic [2:0]       r_phase, n_phase, c_phase;
    logic [3:0]       r_idx, n_idx, c_idx;
    logic [7:0]       r_crc, n_crc, c_crc;
    logic [31:0]      r_buf, n_buf, c_buf;
    logic             r_crc_good, n_crc_good, c_crc_good;
    logic             r_crc_failed, n_crc_failed, c_crc_failed;
    logic             r_nonfinite, n_nonfinite, c_nonfinite;
    logic [3:0]       r_values_used;
    logic [3:0]       eff_cnt;

    logic             accept;
    logic             emit;
    logic             finite;
    logic             is_last;
    crcwfd_pkg::t_status status;

    logic                r_out_valid;
    logic [31:0]         r_value_bits;
    logic [3:0]          r_value_index;
    logic                r_value_crc_ok;
    logic                r_value_finite;
    crcwfd_pkg::t_status r_frame_status;
    logic                r_last;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    always_comb begin
        eff_cnt = r_values_used;
        if (eff_cnt == 4'd0) begin
            eff_cnt = 4'd1;
        end
        if (eff_cnt > crcwfd_pkg::MAX_VALUES) begin
            eff_cnt = crcwfd_pkg::MAX_VALUES;
        end
        if (eff_cnt > CAP) begin
            eff_cnt = CAP;
        end
    end

    always_comb begin
        // frame start clears everything before the byte counts as byte 0
        if (i_frame_start) begin
            c_pos        = '0;
            c_phase      = '0;
            c_idx        = '0;
            c_crc        = crcwfd_pkg::CRC_INIT;
            c_buf        = '0;
            c_crc_good   = 1'b1;
            c_crc_failed = 1'b0;
            c_nonfinite  = 1'b0;
        end else begin
            c_pos        = r_pos;
            c_phase      = r_phase;
            c_idx        = r_idx;
            c_crc        = r_crc;
            c_buf        = r_buf;
            c_crc_good   = r_crc_good;
            c_crc_failed = r_crc_failed;
            c_nonfinite  = r_nonfinite;
        end

        n_pos        = c_pos;
        n_phase      = c_phase;
        n_idx        = c_idx;
        n_crc        = c_crc;
        n_buf        = c_buf;
        n_crc_good   = c_crc_good;
        n_crc_failed = c_crc_failed;
        n_nonfinite  = c_nonfinite;
        emit         = 1'b0;

        // bytes past the end of the frame are dropped until the next frame start
        if (c_pos < POS_W'(FRAME_BYTES)) begin
            n_pos = c_pos + POS_W'(1);
            if (c_phase == crcwfd_pkg::PH_CRC_LO) begin
                n_phase = crcwfd_pkg::PH_FIRST;
                n_idx   = c_idx + 4'd1;
            end else begin
                n_phase = c_phase + 3'd1;
            end

            if (c_phase == crcwfd_pkg::PH_FIRST) begin
                n_crc_good = 1'b1;
            end

            if (c_phase == crcwfd_pkg::PH_CRC_HI || c_phase == crcwfd_pkg::PH_CRC_LO) begin
                if (c_crc != i_rx_byte) begin
                    n_crc_good = 1'b0;
                end
                n_crc = crcwfd_pkg::CRC_INIT;
            end else begin
                n_crc = crcwfd_pkg::crc_byte(c_crc, i_rx_byte);
                n_buf = {c_buf[23:0], i_rx_byte};
            end

            emit = (c_phase == crcwfd_pkg::PH_CRC_LO) && (c_idx < eff_cnt);
        end

        finite  = (n_buf[30:23] != 8'hFF);
        is_last = ((c_idx + 4'd1) == eff_cnt);
        if (emit) begin
            if (!n_crc_good) begin
                n_crc_failed = 1'b1;
            end
            if (!finite) begin
                n_nonfinite = 1'b1;
            end
        end

        status = crcwfd_pkg::STATUS_OK;
        if (is_last) begin
            if (n_crc_failed) begin
                status = crcwfd_pkg::STATUS_CRC_ERR;
            end else if (n_nonfinite) begin
                status = crcwfd_pkg::STATUS_NONFINITE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_values_used <= crcwfd_pkg::VALUES_RESET;
        end else if (i_cfg_we) begin
            r_values_used <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_phase      <= '0;
            r_idx        <= '0;
            r_crc        <= crcwfd_pkg::CRC_INIT;
            r_buf        <= '0;
            r_crc_good   <= 1'b1;
            r_crc_failed <= 1'b0;
            r_nonfinite  <= 1'b0;
        end else if (accept) begin
            r_pos        <= n_pos;
            r_phase      <= n_phase;
            r_idx        <= n_idx;
            r_crc        <= n_crc;
            r_buf        <= n_buf;
            r_crc_good   <= n_crc_good;
            r_crc_failed <= n_crc_failed;
            r_nonfinite  <= n_nonfinite;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_value_bits   <= n_buf;
            r_value_index  <= c_idx;
            r_value_crc_ok <= n_crc_good;
            r_value_finite <= finite;
            r_frame_status <= status;
            r_last         <= is_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_value_bits   = r_value_bits;
    assign o_value_index  = r_value_index;
    assign o_value_crc_ok = r_value_crc_ok;
    assign o_value_finite = r_value_finite;
    assign o_frame_status = r_frame_status;
    assign o_last         = r_last;

endmodule

`default_nettype wire

/* rtl/crcwfd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module crcwfd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [31:0] o_value_bits,
    input wire logic [3:0]  o_value_index,
    input wire logic        o_value_crc_ok,
    input wire logic        o_value_finite,
    input wire logic [1:0]  o_frame_status,
    input wire logic        o_last
);

    // a stalled result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_value_bits)
            && $stable(o_value_index) && $stable(o_last))
        else $error("stalled result changed");

    // status is only reported on the last value
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_status != crcwfd_pkg::STATUS_OK |-> o_last)
        else $error("frame status on a non-last value");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_value_index < crcwfd_pkg::MAX_VALUES)
        else $error("value index out of range");

    // crc error on the last value itself wins over everything
    a_crc_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last && !o_value_crc_ok |->
            o_frame_status == crcwfd_pkg::STATUS_CRC_ERR)
        else $error("crc error not reported on last value");

    a_nonfinite_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last && !o_value_finite |->
            o_frame_status == crcwfd_pkg::STATUS_CRC_ERR
            || o_frame_status == crcwfd_pkg::STATUS_NONFINITE)
        else $error("non-finite last value reported ok");

endmodule

bind crc_checked_word_frame_decoder_unit crcwfd_checker u_crcwfd_checker (.*);

`default_nettype wire
